@@ hdl/simplex_noise_fbm_height_core_macros.svh @@
// assertion macros for the simplex noise height core
// used by the top level only; expands to nothing when SYNTHESIS is defined
`ifndef SIMPLEX_NOISE_FBM_HEIGHT_CORE_MACROS_SVH
`define SIMPLEX_NOISE_FBM_HEIGHT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SNF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("snf check failed");
`define SNF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("snf check failed");
`define SNF_ASSERT_LATER(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error("snf check failed");
`else
`define SNF_ASSERT_IMPL(label, ante, cons)
`define SNF_ASSERT_NEXT(label, ante, cons)
`define SNF_ASSERT_LATER(label, ante, cons)
`endif
`endif

@@ hdl/snf_pkg.sv @@
// shared types, fixed-point constants and the octave amplitude table
// no dependencies
`default_nettype none
package snf_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_BITS  = 12;
   localparam int MAX_OCTAVES = 8;
   localparam int PERM_DEPTH  = 512;
   localparam int PERM_AW     = $clog2(PERM_DEPTH);
   localparam int QUEUE_DEPTH = 4;
   localparam int RSP_DEPTH   = 16;
   localparam int NSTAGE      = 16;
   localparam int NCORNER     = 3;

   localparam int QONE       = 1 << FRAC_BITS;
   localparam int QHALF      = 1 << (FRAC_BITS - 1);
   localparam int SKEW_Q     = 23988;
   localparam int UNSKEW_Q   = 13849;
   localparam int PERSIST_Q  = 42598;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_BASE_FREQ = 2'd0,
      CSR_OCTAVES   = 2'd1,
      CSR_FLOOR     = 2'd2,
      CSR_SPAN      = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type                  op;
      logic [COORD_BITS-1:0]   x_coord;
      logic [COORD_BITS-1:0]   y_coord;
      logic [PERM_AW-1:0]      table_index;
      logic [7:0]              table_value;
   } item_type;

   typedef struct packed {
      logic       first;
      logic       last;
      logic       mute;
      logic [2:0] k;
   } tag_type;

   typedef struct packed {
      logic reserve;
      logic load_wr;
      logic reads_pending;
   } eng_status_type;

   typedef struct packed {
      logic               valid;
      logic signed [27:0] total;
   } done_type;

   typedef logic [15:0] amp_table_type [MAX_OCTAVES];

   function automatic amp_table_type amp_table_f();
      amp_table_type tab;
      logic [31:0]   a;
      a = 32'(PERSIST_Q);
      for (int k = 0; k < MAX_OCTAVES; k++) begin
         tab[k] = a[15:0];
         a = (a * 32'(PERSIST_Q)) >> FRAC_BITS;
      end
      return tab;
   endfunction

   localparam amp_table_type AMP_TABLE = amp_table_f();

endpackage
`default_nettype wire

@@ hdl/snf_front.sv @@
// request front end: unpacks and classifies requests into a short queue
// depends on snf_pkg
`default_nettype none
module snf_front import snf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [47:0] in_data,
   input  logic        in_user,
   output logic        head_valid,
   output item_type    head_item,
   input  logic        head_pop
);

   localparam int QAW = $clog2(QUEUE_DEPTH);

   item_type       q_ff [QUEUE_DEPTH];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QAW:0]   cnt_ff;
   item_type       item_in;
   logic           push, pop;

   always_comb begin
      item_in.op          = op_type'(in_user);
      item_in.x_coord     = in_data[11:0];
      item_in.y_coord     = in_data[23:12];
      item_in.table_index = in_data[32:24];
      item_in.table_value = in_data[40:33];
   end

   assign in_ready   = (cnt_ff != (QAW+1)'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = q_ff[rd_ff];
   assign push       = in_valid & in_ready;
   assign pop        = head_pop & head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= item_in;
   end

endmodule
`default_nettype wire

@@ hdl/snf_octave_engine.sv @@
// back end: octave sequencer, permutation table copies and the simplex pipeline
// depends on snf_pkg
`default_nettype none
module snf_octave_engine import snf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [23:0]    base_frequency,
   input  logic [3:0]     octave_count,
   input  logic           head_valid,
   input  item_type       head_item,
   output logic           head_pop,
   input  logic           credit_ok,
   output eng_status_type status,
   output done_type       done
);

   localparam logic signed [19:0] QONE_D   = 20'(QONE);
   localparam logic signed [19:0] UNSKEW_D = 20'(UNSKEW_Q);

   // sequencer
   logic [NSTAGE-1:0] v_ff;
   tag_type           tag_ff [NSTAGE];
   tag_type           tag_in;
   logic [2:0]        k_ff, k_in, last_k;
   logic [3:0]        octs;
   logic              mute, is_eval, issue, load_wr, reads_pending;

   always_comb begin
      octs    = (octave_count > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octave_count;
      mute    = (octs == 4'd0);
      last_k  = mute ? 3'd0 : 3'(octs - 4'd1);
      is_eval = (head_item.op == OP_EVAL);
      // a table write must not overtake reads of octaves already issued
      // (first read leaving stage 6, second read leaving stage 7)
      reads_pending = |v_ff[6:0];
      issue   = head_valid & is_eval & ((k_ff != 3'd0) | credit_ok);
      load_wr = head_valid & !is_eval & !reads_pending;
      head_pop = load_wr | (issue & (k_ff == last_k));
      k_in    = k_ff;
      if (issue) k_in = (k_ff == last_k) ? 3'd0 : k_ff + 3'd1;
      tag_in.first = (k_ff == 3'd0);
      tag_in.last  = (k_ff == last_k);
      tag_in.mute  = mute;
      tag_in.k     = k_ff;
      status.reserve       = issue & (k_ff == 3'd0);
      status.load_wr       = load_wr;
      status.reads_pending = reads_pending;
   end

   logic               done_valid_ff;
   logic signed [27:0] done_total_ff;
   logic signed [27:0] acc_ff, acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff          <= '0;
         k_ff          <= '0;
         done_valid_ff <= 1'b0;
      end else begin
         v_ff          <= {v_ff[NSTAGE-2:0], issue};
         k_ff          <= k_in;
         done_valid_ff <= v_ff[NSTAGE-1] & tag_ff[NSTAGE-1].last;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= tag_in;
      for (int i = 1; i < NSTAGE; i++) tag_ff[i] <= tag_ff[i-1];
   end

   // stage registers
   logic [11:0]        x_s0_ff, y_s0_ff;
   logic [30:0]        f_s0_ff;
   logic [34:0]        xq_s1_ff, yq_s1_ff, xq_s2_ff, yq_s2_ff, xq_s3_ff, yq_s3_ff, s_s3_ff;
   logic [35:0]        sum_s2_ff;
   logic [19:0]        ci_s4_ff, cj_s4_ff, xl_s4_ff, yl_s4_ff;
   logic [19:0]        t_s5_ff, xl_s5_ff, yl_s5_ff;
   logic [7:0]         ci_s5_ff, cj_s5_ff, ii_s6_ff, jj_s6_ff, ii_s7_ff;
   logic signed [19:0] x0_s6_ff, y0_s6_ff;
   logic               i1_s7_ff;
   logic signed [19:0] dx_s7_ff [NCORNER], dy_s7_ff [NCORNER];
   logic [7:0]         pa_s7_ff [NCORNER];
   logic [15:0]        sqx_s8_ff [NCORNER], sqy_s8_ff [NCORNER];
   logic               ok_s8_ff [NCORNER];
   logic signed [16:0] dx_s8_ff [NCORNER], dy_s8_ff [NCORNER];
   logic [2:0]         hash_s8_ff [NCORNER];
   logic [15:0]        t_s9_ff [NCORNER], t2_s10_ff [NCORNER], t4_s11_ff [NCORNER];
   logic signed [18:0] g_s9_ff [NCORNER], g_s10_ff [NCORNER], g_s11_ff [NCORNER];
   logic signed [15:0] c_s12_ff [NCORNER];
   logic signed [17:0] n_s13_ff;
   logic signed [23:0] nz_s14_ff, prod_s15_ff;

   // combinational helpers
   logic [42:0]        px, py;
   logic [50:0]        sp;
   logic [35:0]        cx, cy;
   logic [20:0]        csum;
   logic [34:0]        tp;
   logic               i1;
   logic signed [19:0] dx_s7_in [NCORNER], dy_s7_in [NCORNER];
   logic [PERM_AW-1:0] addr_a [NCORNER], addr_b [NCORNER];
   logic signed [33:0] sqx [NCORNER], sqy [NCORNER];
   logic signed [18:0] tt [NCORNER], us [NCORNER], vs2 [NCORNER];
   logic signed [16:0] u [NCORNER], v [NCORNER];
   logic [31:0]        t2p [NCORNER], t4p [NCORNER];
   logic signed [35:0] pc [NCORNER];
   logic signed [40:0] pp;

   always_comb begin
      px   = 43'(x_s0_ff) * 43'(f_s0_ff);
      py   = 43'(y_s0_ff) * 43'(f_s0_ff);
      sp   = 51'(sum_s2_ff) * 51'(SKEW_Q);
      cx   = {1'b0, xq_s3_ff} + {1'b0, s_s3_ff};
      cy   = {1'b0, yq_s3_ff} + {1'b0, s_s3_ff};
      csum = {1'b0, ci_s4_ff} + {1'b0, cj_s4_ff};
      tp   = 35'(csum) * 35'(UNSKEW_Q);
      i1   = (x0_s6_ff > y0_s6_ff);
      // corner offsets: origin, middle corner, far corner
      dx_s7_in[0] = x0_s6_ff;
      dy_s7_in[0] = y0_s6_ff;
      dx_s7_in[1] = x0_s6_ff - (i1 ? QONE_D : 20'sd0) + UNSKEW_D;
      dy_s7_in[1] = y0_s6_ff - (i1 ? 20'sd0 : QONE_D) + UNSKEW_D;
      dx_s7_in[2] = x0_s6_ff - QONE_D + (UNSKEW_D <<< 1);
      dy_s7_in[2] = y0_s6_ff - QONE_D + (UNSKEW_D <<< 1);
      addr_a[0] = {1'b0, jj_s6_ff};
      addr_a[1] = {1'b0, jj_s6_ff} + PERM_AW'(!i1);
      addr_a[2] = {1'b0, jj_s6_ff} + PERM_AW'(1);
      addr_b[0] = {1'b0, ii_s7_ff} + {1'b0, pa_s7_ff[0]};
      addr_b[1] = {1'b0, ii_s7_ff} + {1'b0, pa_s7_ff[1]} + PERM_AW'(i1_s7_ff);
      addr_b[2] = {1'b0, ii_s7_ff} + {1'b0, pa_s7_ff[2]} + PERM_AW'(1);
      for (int c = 0; c < NCORNER; c++) begin
         sqx[c] = $signed(dx_s7_ff[c][16:0]) * $signed(dx_s7_ff[c][16:0]);
         sqy[c] = $signed(dy_s7_ff[c][16:0]) * $signed(dy_s7_ff[c][16:0]);
         tt[c]  = $signed(19'(QHALF)) - $signed({3'b000, sqx_s8_ff[c]})
                  - $signed({3'b000, sqy_s8_ff[c]});
         u[c]   = hash_s8_ff[c][2] ? dy_s8_ff[c] : dx_s8_ff[c];
         v[c]   = hash_s8_ff[c][2] ? dx_s8_ff[c] : dy_s8_ff[c];
         us[c]  = {{2{u[c][16]}}, u[c]};
         vs2[c] = {v[c][16], v[c], 1'b0};
         t2p[c] = 32'(t_s9_ff[c]) * 32'(t_s9_ff[c]);
         t4p[c] = 32'(t2_s10_ff[c]) * 32'(t2_s10_ff[c]);
         pc[c]  = $signed({1'b0, t4_s11_ff[c]}) * g_s11_ff[c];
      end
      pp = nz_s14_ff * $signed({1'b0, AMP_TABLE[tag_ff[14].k]});
      acc_in = (tag_ff[NSTAGE-1].first ? 28'sd0 : acc_ff)
               + {{4{prod_s15_ff[23]}}, prod_s15_ff};
   end

   // three copies of the table, each with its own pair of read ports
   for (genvar c = 0; c < NCORNER; c++) begin : g_copy
      logic [7:0] perm_mem [PERM_DEPTH];
      always_ff @(posedge clock) begin
         if (load_wr) perm_mem[head_item.table_index] <= head_item.table_value;
         pa_s7_ff[c]   <= perm_mem[addr_a[c]];
         hash_s8_ff[c] <= perm_mem[addr_b[c]][2:0];
      end
   end

   always_ff @(posedge clock) begin
      x_s0_ff   <= head_item.x_coord;
      y_s0_ff   <= head_item.y_coord;
      f_s0_ff   <= 31'(base_frequency) << k_ff;
      xq_s1_ff  <= px[42:8];
      yq_s1_ff  <= py[42:8];
      sum_s2_ff <= {1'b0, xq_s1_ff} + {1'b0, yq_s1_ff};
      xq_s2_ff  <= xq_s1_ff;
      yq_s2_ff  <= yq_s1_ff;
      s_s3_ff   <= sp[50:16];
      xq_s3_ff  <= xq_s2_ff;
      yq_s3_ff  <= yq_s2_ff;
      ci_s4_ff  <= cx[35:16];
      cj_s4_ff  <= cy[35:16];
      xl_s4_ff  <= xq_s3_ff[19:0];
      yl_s4_ff  <= yq_s3_ff[19:0];
      t_s5_ff   <= tp[19:0];
      xl_s5_ff  <= xl_s4_ff;
      yl_s5_ff  <= yl_s4_ff;
      ci_s5_ff  <= ci_s4_ff[7:0];
      cj_s5_ff  <= cj_s4_ff[7:0];
      // unskewed offset, only the low bits survive the wrap
      x0_s6_ff  <= $signed(xl_s5_ff + t_s5_ff - {ci_s5_ff[3:0], 16'h0000});
      y0_s6_ff  <= $signed(yl_s5_ff + t_s5_ff - {cj_s5_ff[3:0], 16'h0000});
      ii_s6_ff  <= ci_s5_ff;
      jj_s6_ff  <= cj_s5_ff;
      ii_s7_ff  <= ii_s6_ff;
      i1_s7_ff  <= i1;
      for (int c = 0; c < NCORNER; c++) begin
         dx_s7_ff[c]  <= dx_s7_in[c];
         dy_s7_ff[c]  <= dy_s7_in[c];
         sqx_s8_ff[c] <= sqx[c][31:16];
         sqy_s8_ff[c] <= sqy[c][31:16];
         ok_s8_ff[c]  <= (dx_s7_ff[c] > -QONE_D) && (dx_s7_ff[c] < QONE_D) &&
                         (dy_s7_ff[c] > -QONE_D) && (dy_s7_ff[c] < QONE_D);
         dx_s8_ff[c]  <= dx_s7_ff[c][16:0];
         dy_s8_ff[c]  <= dy_s7_ff[c][16:0];
         t_s9_ff[c]   <= (!ok_s8_ff[c] || tt[c] < 0) ? 16'h0000 : tt[c][15:0];
         g_s9_ff[c]   <= (hash_s8_ff[c][0] ? -us[c] : us[c])
                         + (hash_s8_ff[c][1] ? -vs2[c] : vs2[c]);
         t2_s10_ff[c] <= t2p[c][31:16];
         g_s10_ff[c]  <= g_s9_ff[c];
         t4_s11_ff[c] <= t4p[c][31:16];
         g_s11_ff[c]  <= g_s10_ff[c];
         c_s12_ff[c]  <= pc[c][31:16];
      end
      n_s13_ff      <= 18'(c_s12_ff[0]) + 18'(c_s12_ff[1]) + 18'(c_s12_ff[2]);
      nz_s14_ff     <= (24'(n_s13_ff) <<< 5) + (24'(n_s13_ff) <<< 3);
      prod_s15_ff   <= tag_ff[14].mute ? 24'sd0 : pp[39:16];
      if (v_ff[NSTAGE-1]) acc_ff <= acc_in;
      done_total_ff <= acc_in;
   end

   assign done = '{valid: done_valid_ff, total: done_total_ff};

endmodule
`default_nettype wire

@@ hdl/snf_result.sv @@
// result end: saturation, height mapping, result queue and slot reservation
// depends on snf_pkg
`default_nettype none
module snf_result import snf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  height_floor,
   input  logic [7:0]  height_span,
   input  done_type    done,
   input  logic        reserve,
   output logic        credit_ok,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_data
);

   localparam int RAW = $clog2(RSP_DEPTH);

   logic               v_r1_ff;
   logic [19:0]        nv_r1_ff, nv_in;
   logic [16:0]        norm_r1_ff, norm_in;
   logic signed [17:0] cl;
   logic [17:0]        shifted;
   logic [24:0]        hp;
   logic [9:0]         hs;
   logic [7:0]         h_in;
   logic [27:0]        q_ff [RSP_DEPTH];
   logic [RAW-1:0]     wr_ff, rd_ff;
   logic [RAW:0]       cnt_ff, res_ff;
   logic               pop;

   always_comb begin
      if (done.total > 28'sd524287) nv_in = 20'h7FFFF;
      else if (done.total < -28'sd524288) nv_in = 20'h80000;
      else nv_in = done.total[19:0];
      if (done.total > 28'sd65536) cl = 18'sd65536;
      else if (done.total < -28'sd65536) cl = -18'sd65536;
      else cl = done.total[17:0];
      shifted = 18'(cl + 18'sd65536);
      norm_in = shifted[17:1];
      hp      = 25'(height_span) * 25'(norm_r1_ff);
      hs      = {2'b00, height_floor} + {1'b0, hp[24:16]};
      h_in    = (hs > 10'd255) ? 8'hFF : hs[7:0];
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = {4'h0, q_ff[rd_ff]};
   assign pop       = out_valid & out_ready;
   // a slot is held from the first octave until its result leaves
   assign credit_ok = (res_ff < (RAW+1)'(RSP_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_r1_ff <= 1'b0;
         wr_ff   <= '0;
         rd_ff   <= '0;
         cnt_ff  <= '0;
         res_ff  <= '0;
      end else begin
         v_r1_ff <= done.valid;
         if (v_r1_ff) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         if (v_r1_ff && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !v_r1_ff) cnt_ff <= cnt_ff - 1'b1;
         if (reserve && !pop) res_ff <= res_ff + 1'b1;
         else if (pop && !reserve) res_ff <= res_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      nv_r1_ff   <= nv_in;
      norm_r1_ff <= norm_in;
      if (v_r1_ff) q_ff[wr_ff] <= {h_in, nv_r1_ff};
   end

endmodule
`default_nettype wire

@@ hdl/simplex_noise_fbm_height_core.sv @@
// top level of the simplex noise height core: settings registers and wiring
// depends on snf_pkg, snf_front, snf_octave_engine, snf_result and the macro header
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tdata: x, y, index, value; tuser: op
//   rsp      out        rsp_tvalid/tready    tdata: noise, height
//   csr      in         csr_valid/ready      csr_index, csr_data
//
// an evaluate request issues max(1, min(octaves, 8)) octaves into the octave pipeline,
// one per cycle once the first has a result slot; rsp_tvalid rises when the last has
// passed the pipeline, the done register and the result register; a load request is
// written once the first seven pipeline stages hold no octave; up to 16 results may be
// outstanding; then rsp stalls hold back the next evaluate and every request queued behind it
// reset is synchronous; the permutation table is not cleared and must be loaded
`default_nettype none
`include "simplex_noise_fbm_height_core_macros.svh"
module simplex_noise_fbm_height_core import snf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x_coord, y_coord, table_index, table_value, pad
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // noise_value, height_value, pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   logic [23:0]    base_frequency_ff;
   logic [3:0]     octave_count_ff;
   logic [7:0]     height_floor_ff, height_span_ff;
   logic           head_valid, head_pop, credit_ok;
   item_type       head_item;
   eng_status_type eng_status;
   done_type       done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_frequency_ff <= 24'd7000;
         octave_count_ff   <= 4'd6;
         height_floor_ff   <= 8'd7;
         height_span_ff    <= 8'd30;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_FREQ: base_frequency_ff <= csr_data;
            CSR_OCTAVES:   octave_count_ff   <= csr_data[3:0];
            CSR_FLOOR:     height_floor_ff   <= csr_data[7:0];
            CSR_SPAN:      height_span_ff    <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   snf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .in_user    (req_tuser),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   snf_octave_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .base_frequency (base_frequency_ff),
      .octave_count   (octave_count_ff),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .head_pop       (head_pop),
      .credit_ok      (credit_ok),
      .status         (eng_status),
      .done           (done)
   );

   snf_result u_result (
      .clock        (clock),
      .reset        (reset),
      .height_floor (height_floor_ff),
      .height_span  (height_span_ff),
      .done         (done),
      .reserve      (eng_status.reserve),
      .credit_ok    (credit_ok),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (rsp_tdata)
   );

   `SNF_ASSERT_IMPL(a_reserve_has_room, eng_status.reserve, credit_ok)
   `SNF_ASSERT_IMPL(a_load_after_reads, eng_status.load_wr, !eng_status.reads_pending)
   `SNF_ASSERT_LATER(a_done_reaches_rsp, done.valid, rsp_tvalid)
   `SNF_ASSERT_IMPL(a_load_pops_head, eng_status.load_wr, head_pop && head_valid)

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking bench for simplex_noise_fbm_height_core: fills the permutation table,
// runs a directed table and random phases, checks every response against a predictor
// or a typed expected value; depends on snf_pkg and the core rtl
`default_nettype none
module tb;
   import snf_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 60;
   // entries below HASH_ONLY_BASE feed the second lookup, so they hold small bytes
   // and every read stays inside the first FILL_DEPTH entries
   localparam int FILL_DEPTH     = 320;
   localparam int HASH_ONLY_BASE = 257;
   localparam int LOW_VALUE_MAX  = 63;
   localparam int RANDOM_PER_PH  = 19;

   typedef struct packed {
      logic [19:0] noise;
      logic [7:0]  height;
   } height_result_type;

   typedef struct {
      logic          is_csr;
      csr_index_type csr_idx;
      logic [23:0]   csr_val;
      op_type        op;
      int            x;
      int            y;
      int            tidx;
      int            tval;
      logic          typed;
      logic [19:0]   noise;
      logic [7:0]    height;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // x_coord, y_coord, table_index, table_value, pad
   logic        req_tuser = 1'b0; // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // noise_value, height_value, pad
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   simplex_noise_fbm_height_core DUT (.*);

   // predictor state
   logic [7:0]  perm_copy [PERM_DEPTH];
   logic [23:0] freq_reg;
   logic [3:0]  oct_reg;
   logic [7:0]  floor_reg;
   logic [7:0]  span_reg;

   height_result_type pending_heights [$];
   stim_row_type      rows [$];
   int errors = 0;
   int n_results = 0;
   int n_evals = 0;
   int n_loads = 0;
   int idle_cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // fixed-point helpers, products floored
   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic longint corner_term(longint dx, longint dy, int hash);
      longint t, u, v, g;
      int h;
      h = hash & 7;
      if (dx >= QONE || dx <= -QONE || dy >= QONE || dy <= -QONE) return 0;
      t = QHALF - qmul(dx, dx) - qmul(dy, dy);
      if (t < 0) return 0;
      t = qmul(t, t);
      t = qmul(t, t);
      u = (h < 4) ? dx : dy;
      v = (h < 4) ? dy : dx;
      g = ((h & 1) ? -u : u) + ((h & 2) ? -2 * v : 2 * v);
      return qmul(t, g);
   endfunction

   function automatic int perm_at(longint i);
      return perm_copy[i & (PERM_DEPTH - 1)];
   endfunction

   function automatic longint simplex_cell(longint xq, longint yq);
      longint sum, s, ci, cj, t, x0, y0, i1, j1, n;
      int ii, jj;
      sum = xq + yq;
      s = (sum >> FRAC_BITS) * SKEW_Q + (((sum & (QONE - 1)) * SKEW_Q) >> FRAC_BITS);
      ci = (xq + s) >> FRAC_BITS;
      cj = (yq + s) >> FRAC_BITS;
      t = (ci + cj) * UNSKEW_Q;
      x0 = xq + t - (ci << FRAC_BITS);
      y0 = yq + t - (cj << FRAC_BITS);
      i1 = (x0 > y0) ? 1 : 0;
      j1 = 1 - i1;
      ii = int'(ci & 255);
      jj = int'(cj & 255);
      n = corner_term(x0, y0, perm_at(ii + perm_at(jj)));
      n += corner_term(x0 - i1 * QONE + UNSKEW_Q, y0 - j1 * QONE + UNSKEW_Q,
                       perm_at(ii + i1 + perm_at(jj + j1)));
      n += corner_term(x0 - QONE + 2 * UNSKEW_Q, y0 - QONE + 2 * UNSKEW_Q,
                       perm_at(ii + 1 + perm_at(jj + 1)));
      return 40 * n;
   endfunction

   function automatic height_result_type predict_height(int xc, int yc);
      height_result_type r;
      longint total, amp, f, xq, yq, nv, c, norm, h;
      int octs;
      total = 0;
      amp = PERSIST_Q;
      octs = (oct_reg > MAX_OCTAVES) ? MAX_OCTAVES : oct_reg;
      for (int k = 0; k < octs; k++) begin
         f = longint'(freq_reg) << k;
         xq = (longint'(xc) * f) >> (24 - FRAC_BITS);
         yq = (longint'(yc) * f) >> (24 - FRAC_BITS);
         total += qmul(simplex_cell(xq, yq), amp);
         amp = qmul(amp, PERSIST_Q);
      end
      nv = total;
      if (nv > 524287) nv = 524287;
      if (nv < -524288) nv = -524288;
      c = total;
      if (c > QONE) c = QONE;
      if (c < -QONE) c = -QONE;
      norm = (c + QONE) >> 1;
      h = floor_reg + ((longint'(span_reg) * norm) >> FRAC_BITS);
      if (h > 255) h = 255;
      r.noise = nv[19:0];
      r.height = h[7:0];
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // table byte that keeps every later read inside the filled entries
   function automatic int pick_value(int tidx);
      if (tidx < HASH_ONLY_BASE) return $urandom_range(0, LOW_VALUE_MAX);
      return $urandom_range(0, 255);
   endfunction

   task automatic send_request(op_type op, int xc, int yc, int tidx, int tval,
                               logic typed, height_result_type typed_res);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, tval[7:0], tidx[8:0], yc[11:0], xc[11:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_LOAD) begin
         perm_copy[tidx] = tval[7:0];
         n_loads++;
      end else begin
         pending_heights = {pending_heights,
                            (typed ? typed_res : predict_height(xc, yc))};
         n_evals++;
      end
   endtask

   // settings change only with the core drained
   task automatic write_csr(csr_index_type idx, logic [23:0] val);
      req_tvalid <= 1'b0;
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BASE_FREQ: freq_reg = val;
         CSR_OCTAVES:   oct_reg = val[3:0];
         CSR_FLOOR:     floor_reg = val[7:0];
         CSR_SPAN:      span_reg = val[7:0];
         default: begin
         end
      endcase
   endtask

   function automatic void add_row(stim_row_type row);
      rows = {rows, row};
   endfunction

   function automatic stim_row_type csr_row(csr_index_type idx, logic [23:0] val);
      stim_row_type r;
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      r.op = OP_LOAD;
      r.x = 0;
      r.y = 0;
      r.tidx = 0;
      r.tval = 0;
      r.typed = 1'b0;
      r.noise = '0;
      r.height = '0;
      return r;
   endfunction

   function automatic stim_row_type req_row(op_type op, int xc, int yc, int tidx, int tval,
                                            logic typed, logic [19:0] nz, logic [7:0] ht);
      stim_row_type r;
      r.is_csr = 1'b0;
      r.csr_idx = CSR_BASE_FREQ;
      r.csr_val = '0;
      r.op = op;
      r.x = xc;
      r.y = yc;
      r.tidx = tidx;
      r.tval = tval;
      r.typed = typed;
      r.noise = nz;
      r.height = ht;
      return r;
   endfunction

   // response side: random back-pressure and checking
   int stall_left = 0;
   always @(posedge clock) begin
      height_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.noise = rsp_tdata[19:0];
         got.height = rsp_tdata[27:20];
         n_results++;
         if (pending_heights.size() == 0) begin
            $display("%0t: unexpected response noise=%h height=%0d", $time,
                     got.noise, got.height);
            errors++;
         end else begin
            want = pending_heights.pop_front();
            if (got.noise !== want.noise) begin
               $display("%0t: noise mismatch expected %h actual %h", $time,
                        want.noise, got.noise);
               errors++;
            end
            if (got.height !== want.height) begin
               $display("%0t: height mismatch expected %0d actual %0d", $time,
                        want.height, got.height);
               errors++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_tready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d responses outstanding", $time,
                  pending_heights.size());
         $display("[simplex_noise_fbm_height_core] ERROR");
         $finish;
      end
   end

   initial begin
      height_result_type typed_res;
      logic [23:0] fq;
      int r;
      int tidx_r;
      freq_reg = 24'd7000;
      oct_reg = 4'd6;
      floor_reg = 8'd7;
      span_reg = 8'd30;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every entry that an evaluate can reach is written before any evaluate
      for (int i = 0; i < FILL_DEPTH; i++)
         send_request(OP_LOAD, 0, 0, i, pick_value(i), 1'b0, '0);

      add_row(req_row(OP_EVAL, 0, 0, 0, 0, 0, '0, '0));
      add_row(req_row(OP_EVAL, 4095, 4095, 0, 0, 0, '0, '0));
      add_row(req_row(OP_EVAL, 0, 4095, 0, 0, 0, '0, '0));
      add_row(req_row(OP_EVAL, 4095, 0, 0, 0, 0, '0, '0));
      add_row(req_row(OP_LOAD, 0, 0, 0, LOW_VALUE_MAX, 0, '0, '0));
      add_row(req_row(OP_LOAD, 0, 0, 511, 255, 0, '0, '0));
      add_row(req_row(OP_LOAD, 0, 0, FILL_DEPTH - 1, 255, 0, '0, '0));
      add_row(req_row(OP_LOAD, 0, 0, HASH_ONLY_BASE - 1, 0, 0, '0, '0));
      add_row(req_row(OP_EVAL, 1, 1, 0, 0, 0, '0, '0));
      // no octaves: noise is zero, height is floor plus half the span, saturated at 255
      add_row(csr_row(CSR_OCTAVES, 24'd0));
      add_row(csr_row(CSR_FLOOR, 24'd255));
      add_row(csr_row(CSR_SPAN, 24'd255));
      add_row(req_row(OP_EVAL, 123, 45, 0, 0, 1, 20'd0, 8'd255));
      add_row(csr_row(CSR_FLOOR, 24'd0));
      add_row(csr_row(CSR_SPAN, 24'd0));
      add_row(req_row(OP_EVAL, 4095, 4095, 0, 0, 1, 20'd0, 8'd0));
      add_row(csr_row(CSR_FLOOR, 24'd7));
      add_row(csr_row(CSR_SPAN, 24'd30));
      add_row(req_row(OP_EVAL, 2048, 17, 0, 0, 1, 20'd0, 8'd22));
      // octave count beyond the maximum with a zero and a full-scale frequency
      add_row(csr_row(CSR_OCTAVES, 24'd15));
      add_row(csr_row(CSR_BASE_FREQ, 24'd0));
      add_row(req_row(OP_EVAL, 4095, 4095, 0, 0, 0, '0, '0));
      add_row(csr_row(CSR_BASE_FREQ, 24'hFFFFFF));
      add_row(req_row(OP_EVAL, 4095, 4095, 0, 0, 0, '0, '0));
      add_row(req_row(OP_EVAL, 3000, 1, 0, 0, 0, '0, '0));

      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            write_csr(rows[i].csr_idx, rows[i].csr_val);
         end else begin
            typed_res.noise = rows[i].noise;
            typed_res.height = rows[i].height;
            send_request(rows[i].op, rows[i].x, rows[i].y, rows[i].tidx, rows[i].tval,
                         rows[i].typed, typed_res);
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_BASE_FREQ, 24'd1);
               write_csr(CSR_OCTAVES, 24'd8);
               write_csr(CSR_FLOOR, 24'd0);
               write_csr(CSR_SPAN, 24'd255);
            end
            1: begin
               write_csr(CSR_BASE_FREQ, 24'hFFFFFF);
               write_csr(CSR_OCTAVES, 24'd1);
               write_csr(CSR_FLOOR, 24'd255);
               write_csr(CSR_SPAN, 24'd0);
            end
            default: begin
               fq = 24'($urandom());
               if ($urandom_range(0, 1)) fq = fq >> $urandom_range(4, 14);
               write_csr(CSR_BASE_FREQ, fq);
               write_csr(CSR_OCTAVES, 24'((ph == 5) ? $urandom_range(9, 15)
                                                    : $urandom_range(1, 8)));
               write_csr(CSR_FLOOR, 24'($urandom_range(0, 255)));
               write_csr(CSR_SPAN, 24'($urandom_range(0, 255)));
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PH; n++) begin
            r = $urandom_range(0, 99);
            tidx_r = $urandom_range(0, PERM_DEPTH - 1);
            if (r < 80)
               send_request(OP_EVAL, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            tidx_r, $urandom_range(0, 255), 1'b0, '0);
            else
               send_request(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            tidx_r, pick_value(tidx_r), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d evaluates and %0d table loads, %0d responses checked",
               n_evals, n_loads, n_results);
      $display("settings swept over frequency, octave, floor and span extremes");
      if (errors == 0)
         $display("[simplex_noise_fbm_height_core] OK");
      else
         $display("[simplex_noise_fbm_height_core] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
